/* sv/kehtn_pkg.sv */
package kehtn_pkg;
	localparam int NUM_CODES_DEF = 256;
	localparam int MAX_SHOWN_DEF = 16;
	localparam int COUNT_BITS_DEF = 32;
	localparam int TOP_W = 5;
	localparam int SCALE_W = 6;
	localparam int RANK_W = 4;
	localparam int CODE_W = 8;
	localparam int HIT_W = 32;
	localparam int BAR_W = 6;
	localparam logic [TOP_W-1:0] TOP_RESET = 5'd10;
	localparam logic [SCALE_W-1:0] SCALE_RESET = 6'd20;
	localparam logic [0:0] REG_TOP = 1'b0;
	localparam logic [0:0] REG_SCALE = 1'b1;

	typedef enum logic [3:0] {
		ST_CLEAR, ST_IDLE, ST_UPD_RD, ST_UPD_WR, ST_SCAN_RD, ST_SCAN_CMP,
		ST_SCAN_INS, ST_OUT_LD, ST_BAR, ST_OUT_HOLD
	} state_t;

	function automatic logic present_at_reset(input int c);
		return (c >= 8 && c <= 9) || (c >= 12 && c <= 13) || (c >= 16 && c <= 20) ||
			(c == 27) || (c >= 32 && c <= 57) || (c >= 65 && c <= 93) ||
			(c >= 96 && c <= 123) || (c >= 144 && c <= 145) ||
			(c >= 160 && c <= 165) || (c >= 173 && c <= 175) ||
			(c >= 186 && c <= 192) || (c >= 219 && c <= 222) || (c == 226);
	endfunction
endpackage

/* sv/kehtn_if.sv */
interface kehtn_in_if;
	logic valid;
	logic ready;
	logic [kehtn_pkg::CODE_W-1:0] key_code;
	logic is_release;
	modport source (output valid, key_code, is_release, input ready);
	modport sink (input valid, key_code, is_release, output ready);
endinterface

interface kehtn_out_if;
	logic valid;
	logic ready;
	logic [kehtn_pkg::RANK_W-1:0] rank;
	logic [kehtn_pkg::CODE_W-1:0] code_out;
	logic [kehtn_pkg::HIT_W-1:0] hit_count;
	logic [kehtn_pkg::BAR_W-1:0] bar_length;
	logic last;
	modport source (output valid, rank, code_out, hit_count, bar_length, last, input ready);
	modport sink (input valid, rank, code_out, hit_count, bar_length, last, output ready);
endinterface

interface kehtn_cfg_if;
	logic valid;
	logic ready;
	logic [0:0] index;
	logic [7:0] data;
	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

/* sv/kehtn_ram.sv */
module kehtn_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule

/* sv/key_event_histogram_top_n.sv */
// Channel  Dir  Payload
// in       in   key_code, is_release
// out      out  rank, code_out, hit_count, bar_length, last
// cfg      in   index (0 top_count, 1 bar_scale), data
// After reset a clearing pass loads the counter memory; no item is taken.
// A press is taken in idle and changes nothing. A release raises its code's saturating counter
// and, unless top_count is zero, sweeps the counter memory entry by entry through its one read
// port, reading and comparing each entry and inserting it when it ranks; each bar is then a
// serial divide over bar_scale steps.
// Output waits hold the sequencer; the next item is taken after the last result is taken.
module key_event_histogram_top_n
	import kehtn_pkg::*;
#(
	parameter int NUM_CODES = NUM_CODES_DEF,
	parameter int MAX_SHOWN = MAX_SHOWN_DEF,
	parameter int COUNT_BITS = COUNT_BITS_DEF
) (
	input logic clk,
	input logic arst_n,
	kehtn_in_if.sink in_ch,
	kehtn_out_if.source out_ch,
	kehtn_cfg_if.sink cfg
);
	localparam int AW = $clog2(NUM_CODES);
	localparam int SW = $clog2(MAX_SHOWN + 1);
	localparam int MW = (MAX_SHOWN > 1) ? $clog2(MAX_SHOWN) : 1;
	localparam int DW = COUNT_BITS + 1;
	localparam logic [COUNT_BITS-1:0] CMAX = '1;

	state_t state_q, state_d;
	logic [TOP_W-1:0] top_q;
	logic [SCALE_W-1:0] scale_q;
	logic [AW:0] addr_q;
	logic [CODE_W-1:0] code_q;
	logic [SW-1:0] want_q, filled_q, k_q, pos_q;
	logic [COUNT_BITS-1:0] cur_q, maxc_q;
	logic [COUNT_BITS-1:0] bcnt_q [MAX_SHOWN];
	logic [CODE_W-1:0] bcode_q [MAX_SHOWN];
	logic [DW-1:0] r_q;
	logic [BAR_W-1:0] q_q;
	logic [SCALE_W-1:0] step_q;
	logic [RANK_W-1:0] rank_q;
	logic [CODE_W-1:0] ocode_q;
	logic [HIT_W-1:0] ohit_q;
	logic olast_q;

	logic we;
	logic [AW-1:0] waddr, raddr;
	logic [COUNT_BITS:0] wdata, rdata;

	kehtn_ram #(.WIDTH(COUNT_BITS + 1), .DEPTH(NUM_CODES)) u_cnt (
		.clk(clk), .we(we), .waddr(waddr), .wdata(wdata), .raddr(raddr), .rdata(rdata)
	);

	logic [SW-1:0] pos_c;
	logic [COUNT_BITS-1:0] rcnt;
	logic rpres;
	logic [COUNT_BITS-1:0] kcnt, diff;
	logic [DW-1:0] r_ge;
	assign rcnt = rdata[COUNT_BITS-1:0];
	assign rpres = rdata[COUNT_BITS];
	assign kcnt = bcnt_q[k_q[MW-1:0]];
	assign diff = maxc_q - kcnt;

	always_comb begin
		pos_c = filled_q;
		for (int i = 0; i < MAX_SHOWN; i++) begin
			if (SW'(i) < filled_q && bcnt_q[i] < rcnt && pos_c == filled_q) begin
				pos_c = SW'(i);
			end
		end
	end

	always_comb begin
		state_d = state_q;
		we = 1'b0;
		waddr = AW'(code_q);
		wdata = {1'b1, cur_q};
		raddr = addr_q[AW-1:0];
		unique case (state_q)
			ST_CLEAR: begin
				we = 1'b1;
				waddr = addr_q[AW-1:0];
				wdata = {present_at_reset(int'(addr_q[AW-1:0])), {COUNT_BITS{1'b0}}};
				if (addr_q == (AW+1)'(NUM_CODES - 1)) state_d = ST_IDLE;
			end
			ST_IDLE: begin
				raddr = AW'(in_ch.key_code);
				if (in_ch.valid) begin
					if (in_ch.is_release && int'(in_ch.key_code) < NUM_CODES)
						state_d = ST_UPD_RD;
				end
			end
			ST_UPD_RD: state_d = ST_UPD_WR;
			ST_UPD_WR: begin
				we = 1'b1;
				if (want_q == '0) state_d = ST_IDLE;
				else state_d = ST_SCAN_RD;
			end
			ST_SCAN_RD: state_d = ST_SCAN_CMP;
			ST_SCAN_CMP: begin
				if (rpres && pos_c < want_q) state_d = ST_SCAN_INS;
				else if (addr_q == (AW+1)'(NUM_CODES - 1)) state_d = ST_OUT_LD;
				else state_d = ST_SCAN_RD;
			end
			ST_SCAN_INS: begin
				if (addr_q == (AW+1)'(NUM_CODES - 1)) state_d = ST_OUT_LD;
				else state_d = ST_SCAN_RD;
			end
			ST_OUT_LD: begin
				if (filled_q == '0) state_d = ST_IDLE;
				else state_d = ST_BAR;
			end
			ST_BAR: begin
				if (step_q == scale_q) state_d = ST_OUT_HOLD;
			end
			ST_OUT_HOLD: begin
				if (out_ch.ready) begin
					if (olast_q) state_d = ST_IDLE;
					else state_d = ST_BAR;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	assign in_ch.ready = (state_q == ST_IDLE);
	assign cfg.ready = 1'b1;
	assign out_ch.valid = (state_q == ST_OUT_HOLD);
	assign out_ch.rank = rank_q;
	assign out_ch.code_out = ocode_q;
	assign out_ch.hit_count = ohit_q;
	assign out_ch.bar_length = q_q;
	assign out_ch.last = olast_q;
	assign r_ge = r_q - DW'(diff);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
			addr_q <= '0;
			top_q <= TOP_RESET;
			scale_q <= SCALE_RESET;
		end else begin
			state_q <= state_d;
			if (cfg.valid) begin
				if (cfg.index == REG_TOP) top_q <= cfg.data[TOP_W-1:0];
				else scale_q <= cfg.data[SCALE_W-1:0];
			end
			if (state_q == ST_UPD_WR || state_q == ST_CLEAR && state_d == ST_IDLE)
				addr_q <= '0;
			else if (state_q == ST_CLEAR || state_q == ST_SCAN_CMP && state_d == ST_SCAN_RD ||
				state_q == ST_SCAN_INS)
				addr_q <= addr_q + 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				code_q <= in_ch.key_code;
				if (int'(top_q) > MAX_SHOWN) want_q <= SW'(MAX_SHOWN);
				else want_q <= SW'(top_q);
				filled_q <= '0;
			end
			ST_UPD_RD: cur_q <= (rcnt == CMAX) ? rcnt : rcnt + 1'b1;
			ST_SCAN_CMP: begin
				cur_q <= rcnt;
				pos_q <= pos_c;
			end
			ST_SCAN_INS: begin
				for (int i = MAX_SHOWN - 1; i > 0; i--) begin
					if (SW'(i) > pos_q) begin
						bcnt_q[i] <= bcnt_q[i-1];
						bcode_q[i] <= bcode_q[i-1];
					end
				end
				bcnt_q[pos_q[MW-1:0]] <= cur_q;
				bcode_q[pos_q[MW-1:0]] <= CODE_W'(addr_q[AW-1:0]);
				if (filled_q < want_q) filled_q <= filled_q + 1'b1;
			end
			ST_OUT_LD: begin
				k_q <= '0;
				maxc_q <= bcnt_q[0];
				r_q <= '0;
				q_q <= '0;
				step_q <= '0;
			end
			ST_BAR: begin
				if (step_q == scale_q) begin
					rank_q <= RANK_W'(k_q);
					ocode_q <= bcode_q[k_q[MW-1:0]];
					ohit_q <= HIT_W'(kcnt);
					olast_q <= (k_q + 1'b1 == filled_q);
					if (maxc_q == '0) q_q <= '0;
				end else begin
					step_q <= step_q + 1'b1;
					if (r_q >= DW'(diff)) begin
						r_q <= r_ge;
						q_q <= q_q + 1'b1;
					end else begin
						r_q <= r_q + DW'(kcnt);
					end
				end
			end
			ST_OUT_HOLD: begin
				if (out_ch.ready) begin
					k_q <= k_q + 1'b1;
					r_q <= '0;
					q_q <= '0;
					step_q <= '0;
				end
			end
			default: ;
		endcase
	end
endmodule

/* tb/sv/key_event_histogram_top_n_checker.sv */
module key_event_histogram_top_n_checker
	import kehtn_pkg::*;
(
	input logic clk,
	input logic arst_n,
	kehtn_in_if in_ch,
	kehtn_out_if out_ch,
	kehtn_cfg_if cfg,
	output int errors,
	output int pending,
	output int releases,
	output int presses,
	output int results,
	output int cfg_writes
);

	typedef struct packed {
		logic [RANK_W-1:0] rank;
		logic [CODE_W-1:0] code;
		logic [HIT_W-1:0] hits;
		logic [BAR_W-1:0] bar;
		logic last;
	} ranking_t;

	logic [HIT_W-1:0] hits [256];
	bit seen [256];
	logic [TOP_W-1:0] top_count;
	logic [SCALE_W-1:0] bar_scale;
	ranking_t ranking_q [$];

	function automatic bit listed_at_reset(int c);
		int lo [13] = '{8, 12, 16, 27, 32, 65, 96, 144, 160, 173, 186, 219, 226};
		int hi [13] = '{9, 13, 20, 27, 57, 93, 123, 145, 165, 175, 192, 222, 226};
		for (int i = 0; i < 13; i++)
			if (c >= lo[i] && c <= hi[i])
				return 1;
		return 0;
	endfunction

	task automatic rank_after_release(logic [CODE_W-1:0] code);
		bit taken [256];
		int picked [16];
		int want;
		int n;
		int best;
		logic [HIT_W-1:0] maxc;
		logic [63:0] bar;
		ranking_t r;
		foreach (taken[i])
			taken[i] = 0;
		n = 0;
		if (hits[code] != '1)
			hits[code]++;
		seen[code] = 1;
		want = (top_count > MAX_SHOWN_DEF) ? MAX_SHOWN_DEF : int'(top_count);
		for (int k = 0; k < want; k++) begin
			best = -1;
			for (int c = 0; c < 256; c++)
				if (seen[c] && !taken[c] && (best < 0 || hits[c] > hits[best]))
					best = c;
			if (best < 0)
				break;
			taken[best] = 1;
			picked[k] = best;
			n++;
		end
		if (n == 0)
			return;
		maxc = hits[picked[0]];
		for (int k = 0; k < n; k++) begin
			bar = (maxc == 0) ? 64'd0 : (64'(hits[picked[k]]) * bar_scale) / maxc;
			r.rank = k[RANK_W-1:0];
			r.code = picked[k][CODE_W-1:0];
			r.hits = hits[picked[k]];
			r.bar = bar[BAR_W-1:0];
			r.last = (k == n - 1);
			ranking_q = {ranking_q, r};
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		ranking_t want_r;
		if (!arst_n) begin
			for (int c = 0; c < 256; c++) begin
				hits[c] = '0;
				seen[c] = listed_at_reset(c);
			end
			top_count = TOP_RESET;
			bar_scale = SCALE_RESET;
			ranking_q.delete();
			pending = 0;
			errors = 0;
			releases = 0;
			presses = 0;
			results = 0;
			cfg_writes = 0;
		end else begin
			if (out_ch.valid && out_ch.ready) begin
				results++;
				if (ranking_q.size() == 0) begin
					errors++;
					$display("%0t: unexpected result rank=%0d code=%0d hits=%0d bar=%0d last=%0b",
						$time, out_ch.rank, out_ch.code_out, out_ch.hit_count,
						out_ch.bar_length, out_ch.last);
				end else begin
					want_r = ranking_q.pop_front();
					if (out_ch.rank !== want_r.rank) begin
						errors++;
						$display("%0t: rank expected %0d actual %0d", $time, want_r.rank,
							out_ch.rank);
					end
					if (out_ch.code_out !== want_r.code) begin
						errors++;
						$display("%0t: code_out expected %0d actual %0d", $time, want_r.code,
							out_ch.code_out);
					end
					if (out_ch.hit_count !== want_r.hits) begin
						errors++;
						$display("%0t: hit_count expected %0d actual %0d", $time, want_r.hits,
							out_ch.hit_count);
					end
					if (out_ch.bar_length !== want_r.bar) begin
						errors++;
						$display("%0t: bar_length expected %0d actual %0d", $time, want_r.bar,
							out_ch.bar_length);
					end
					if (out_ch.last !== want_r.last) begin
						errors++;
						$display("%0t: last expected %0b actual %0b", $time, want_r.last,
							out_ch.last);
					end
				end
			end
			if (cfg.valid && cfg.ready) begin
				cfg_writes++;
				if (cfg.index == REG_TOP)
					top_count = cfg.data[TOP_W-1:0];
				else if (cfg.index == REG_SCALE)
					bar_scale = cfg.data[SCALE_W-1:0];
			end
			if (in_ch.valid && in_ch.ready) begin
				if (in_ch.is_release) begin
					releases++;
					rank_after_release(in_ch.key_code);
				end else begin
					presses++;
				end
			end
			pending = ranking_q.size();
		end
	end

endmodule

/* tb/sv/key_event_histogram_top_n_test.sv */
module key_event_histogram_top_n_test;
	import kehtn_pkg::*;

	logic clk;
	logic arst_n;
	int errors;
	int pending;
	int releases;
	int presses;
	int results;
	int cfg_writes;
	bit hold_now;
	bit stall_on;
	int out_gap;

	kehtn_in_if in_ch ();
	kehtn_out_if out_ch ();
	kehtn_cfg_if cfg ();

	key_event_histogram_top_n u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_ch(in_ch),
		.out_ch(out_ch),
		.cfg(cfg)
	);

	key_event_histogram_top_n_checker u_checker (
		.clk(clk),
		.arst_n(arst_n),
		.in_ch(in_ch),
		.out_ch(out_ch),
		.cfg(cfg),
		.errors(errors),
		.pending(pending),
		.releases(releases),
		.presses(presses),
		.results(results),
		.cfg_writes(cfg_writes)
	);

	function automatic int pick_gap();
		if ($urandom_range(0, 9) == 0)
			return $urandom_range(20, 80);
		return $urandom_range(1, 3);
	endfunction

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	initial begin
		#40_000_000;
		$display("Regression FAIL");
		$finish;
	end

	// receiver
	initial begin
		out_ch.ready = 1'b0;
		out_gap = 0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (hold_now) begin
				out_ch.ready <= 1'b0;
				repeat (4000) @(posedge clk);
				hold_now = 0;
			end else if (out_gap > 0) begin
				out_ch.ready <= 1'b0;
				out_gap--;
			end else begin
				out_ch.ready <= 1'b1;
				if (stall_on && $urandom_range(0, 5) == 0)
					out_gap = pick_gap();
			end
		end
	end

	task automatic send_key(logic [CODE_W-1:0] code, logic rel, bit gaps);
		int gap;
		gap = (gaps && $urandom_range(0, 2) == 0) ? pick_gap() : 0;
		if (gap > 0) begin
			in_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_ch.valid <= 1'b1;
		in_ch.key_code <= code;
		in_ch.is_release <= rel;
		@(posedge clk);
		while (!in_ch.ready)
			@(posedge clk);
	endtask

	task automatic drain();
		in_ch.valid <= 1'b0;
		@(posedge clk);
		while (pending != 0)
			@(posedge clk);
		repeat (20) @(posedge clk);
	endtask

	task automatic write_cfg(logic [7:0] top_data, logic [7:0] scale_data);
		cfg.valid <= 1'b1;
		cfg.index <= REG_TOP;
		cfg.data <= top_data;
		@(posedge clk);
		while (!cfg.ready)
			@(posedge clk);
		cfg.index <= REG_SCALE;
		cfg.data <= scale_data;
		@(posedge clk);
		while (!cfg.ready)
			@(posedge clk);
		cfg.valid <= 1'b0;
		@(posedge clk);
	endtask

	function automatic logic [CODE_W-1:0] pick_code();
		if ($urandom_range(0, 3) == 0)
			return CODE_W'($urandom_range(0, 255));
		return CODE_W'($urandom_range(0, 23) * 11);
	endfunction

	task automatic random_phase(int n_items, bit gaps);
		logic [CODE_W-1:0] code;
		int sent;
		sent = 0;
		while (sent < n_items) begin
			code = pick_code();
			if ($urandom_range(0, 4) != 0) begin
				send_key(code, 1'b0, gaps);
				send_key(code, 1'b1, gaps);
				sent += 2;
			end else begin
				send_key(code, 1'($urandom_range(0, 1)), gaps);
				sent++;
			end
		end
		drain();
	endtask

	initial begin
		arst_n = 1'b0;
		hold_now = 0;
		stall_on = 0;
		in_ch.valid = 1'b0;
		in_ch.key_code = '0;
		in_ch.is_release = 1'b0;
		cfg.valid = 1'b0;
		cfg.index = REG_TOP;
		cfg.data = '0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		send_key(8'd0, 1'b0, 1'b0);
		send_key(8'd0, 1'b1, 1'b0);
		send_key(8'd255, 1'b1, 1'b0);
		send_key(8'd8, 1'b1, 1'b0);
		send_key(8'd8, 1'b1, 1'b0);
		send_key(8'd255, 1'b0, 1'b0);
		send_key(8'd170, 1'b1, 1'b0);
		send_key(8'd85, 1'b1, 1'b0);
		drain();
		write_cfg(8'hFF, 8'hFF);
		send_key(8'd255, 1'b1, 1'b0);
		send_key(8'd0, 1'b1, 1'b0);
		drain();
		write_cfg(8'd16, 8'd63);
		send_key(8'd1, 1'b1, 1'b0);
		send_key(8'd8, 1'b1, 1'b0);
		drain();
		write_cfg(8'd0, 8'd1);
		send_key(8'd1, 1'b1, 1'b0);
		send_key(8'd2, 1'b0, 1'b0);
		drain();
		write_cfg(8'd1, 8'd1);
		send_key(8'd1, 1'b1, 1'b0);
		send_key(8'd3, 1'b1, 1'b0);
		drain();
		write_cfg(8'd17, 8'h40);
		send_key(8'd4, 1'b1, 1'b0);
		send_key(8'd4, 1'b1, 1'b0);
		drain();

		stall_on = 1;
		write_cfg(8'd10, 8'd20);
		random_phase(60, 1'b1);
		write_cfg(8'($urandom_range(0, 255)), 8'($urandom_range(1, 7)));
		hold_now = 1;
		random_phase(50, 1'b0);
		write_cfg(8'($urandom_range(1, 16)), 8'($urandom_range(0, 255)));
		stall_on = 0;
		random_phase(50, 1'b0);
		stall_on = 1;
		write_cfg(8'($urandom_range(0, 31)), 8'($urandom_range(1, 9)));
		random_phase(60, 1'b1);
		write_cfg(8'd16, 8'($urandom_range(1, 12)));
		random_phase(60, 1'b1);
		write_cfg(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
		random_phase(50, 1'b1);

		$display("Covered %0d releases, %0d presses, %0d ranked results, %0d register writes",
			releases, presses, results, cfg_writes);
		$display("including saturated settings, zero top count and a long output hold-off");
		if (errors == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

endmodule
